FILE: hdl/tpfm_pkg.sv
// Shared types, constants and helper functions of the text pattern filter matcher.
`default_nettype none

package tpfm_pkg;

  localparam int PatternMax = 32;
  localparam int PosW       = PatternMax + 1;
  localparam int LenW       = $clog2(PatternMax + 1);
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 64;
  localparam int WordBytes  = CfgDataW / 8;
  localparam int NumWords   = PatternMax / WordBytes;

  localparam logic [7:0] ChAny = 8'h3F;
  localparam logic [7:0] ChRun = 8'h2A;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FILTER_ENABLED = 3'd0,
    REG_MATCH_MODE     = 3'd1,
    REG_CASE_SENSITIVE = 3'd2,
    REG_PATTERN_LENGTH = 3'd3,
    REG_PATTERN_WORD_0 = 3'd4,
    REG_PATTERN_WORD_1 = 3'd5,
    REG_PATTERN_WORD_2 = 3'd6,
    REG_PATTERN_WORD_3 = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_CONTAINS = 2'd0,
    MODE_STARTS   = 2'd1,
    MODE_GLOB     = 2'd2,
    MODE_REGEX    = 2'd3
  } match_mode_e;

  // Settings as the match datapath sees them.
  typedef struct packed {
    logic                              enabled;
    match_mode_e                       mode;
    logic                              case_sensitive;
    logic [LenW-1:0]                   len;
    logic [PatternMax-1:0]             len_mask;
    logic [PatternMax-1:0]             star_mask;
    logic [PatternMax-1:0]             any_mask;
    logic [PatternMax-1:0][7:0]        pat;
  } cfg_t;

  function automatic logic [7:0] fold(input logic [7:0] c, input logic cs);
    logic [7:0] r;
    r = c;
    if (!cs && c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

  // Spread each active position across the run of stars that follows it.
  // Stars propagate a carry, an active star generates one.
  function automatic logic [PosW-1:0] star_closure(input logic [PosW-1:0] act,
                                                   input logic [PatternMax-1:0] star);
    logic [PosW-1:0] a;
    logic [PosW-1:0] b;
    logic [PosW-1:0] s;
    a = {1'b0, star};
    b = act & a;
    s = a + b;
    return act | (s ^ a ^ b);
  endfunction

endpackage

`default_nettype wire

FILE: hdl/tpfm_if.sv
// Handshake channels of the text pattern filter matcher: text in, match out, config write.
`default_nettype none

interface tpfm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       has_byte;
  logic       last;

  modport source (output valid, output text_byte, output has_byte, output last,
                  input ready);
  modport sink   (input valid, input text_byte, input has_byte, input last,
                  output ready);
endinterface

interface tpfm_out_if;
  logic valid;
  logic ready;
  logic matched;

  modport source (output valid, output matched, input ready);
  modport sink   (input valid, input matched, output ready);
endinterface

interface tpfm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tpfm_pkg::CfgIdxW-1:0]    index;
  logic [tpfm_pkg::CfgDataW-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/text_pattern_filter_matcher_top.sv
// Top level of the text pattern filter matcher: input stage, position update, match output.
//
// The block takes one text word per cycle, unless a last word waits in the input stage, and
// keeps no bubbles between texts. Each accepted word is registered, then combinational logic
// updates the 33-bit set of active pattern positions (with the star closure in wildcard mode,
// done as a single 33-bit carry chain). A word marked last hands its final position set to a
// second stage that runs the closure once more for the wildcard verdict and loads the match
// into the output register, so the result passes the input, final-stage and output registers.
// Backpressure on the output stalls only the stages behind a waiting result. Configuration
// writes take effect at once and must be made while no text is in flight.
`default_nettype none

module text_pattern_filter_matcher_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tpfm_cfg_if.sink  cfg_i,
  tpfm_in_if.sink   in_i,
  tpfm_out_if.source out_o
);
  import tpfm_pkg::*;

  cfg_t cfg;

  tpfm_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Input stage
  logic       a_valid_q;
  logic [7:0] a_byte_q;
  logic       a_has_q;
  logic       a_last_q;
  logic       a_adv;
  logic       in_acc;

  // Match state
  logic [PosW-1:0] act_q;
  logic            found_q;

  // Final stage
  logic            b_valid_q;
  logic [PosW-1:0] b_act_q;
  logic            b_found_q;
  logic            b_adv;

  // Output register
  logic o_valid_q;
  logic o_matched_q;

  logic glob;
  assign glob = (cfg.mode == MODE_GLOB);

  assign b_adv  = b_valid_q && (!o_valid_q || out_o.ready);
  assign a_adv  = a_valid_q && (!a_last_q || !b_valid_q || b_adv);
  assign in_i.ready = !a_valid_q || a_adv;
  assign in_acc = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_acc) begin
      a_valid_q <= 1'b1;
    end else if (a_adv) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_byte_q <= in_i.text_byte;
      a_has_q  <= in_i.has_byte;
      a_last_q <= in_i.last;
    end
  end

  // Position update for the registered word
  logic [7:0]            c;
  logic [PosW-1:0]       act_c;
  logic [PatternMax-1:0] eqv;
  logic [PatternMax-1:0] stay;
  logic [PatternMax-1:0] adv;
  logic [PosW-1:0]       nxt;
  logic                  found_n;
  logic [PosW-1:0]       act_after;
  logic                  found_after;

  always_comb begin
    c     = fold(a_byte_q, cfg.case_sensitive);
    act_c = glob ? star_closure(act_q, cfg.star_mask) : act_q;
    for (int i = 0; i < PatternMax; i++) begin
      eqv[i] = (cfg.pat[i] == c);
    end
    if (glob) begin
      stay = act_c[PatternMax-1:0] & cfg.star_mask;
      adv  = act_c[PatternMax-1:0] & cfg.len_mask & ~cfg.star_mask & (cfg.any_mask | eqv);
      nxt  = {1'b0, stay} | {adv, 1'b0};
    end else begin
      stay = '0;
      adv  = act_q[PatternMax-1:0] & cfg.len_mask & eqv;
      nxt  = {adv, (cfg.mode == MODE_CONTAINS)};
    end
    found_n     = found_q | (!glob && (cfg.len != '0) && nxt[cfg.len]);
    act_after   = a_has_q ? nxt : act_q;
    found_after = a_has_q ? found_n : found_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q   <= PosW'(1);
      found_q <= 1'b0;
    end else if (a_adv) begin
      if (a_last_q) begin
        // Text done: rearm for the next one.
        act_q   <= PosW'(1);
        found_q <= 1'b0;
      end else begin
        act_q   <= act_after;
        found_q <= found_after;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (a_adv && a_last_q) begin
      b_valid_q <= 1'b1;
    end else if (b_adv) begin
      b_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv && a_last_q) begin
      b_act_q   <= act_after;
      b_found_q <= found_after;
    end
  end

  // Verdict from the final position set
  logic [PosW-1:0] fin_act;
  logic            hit;

  always_comb begin
    fin_act = star_closure(b_act_q, cfg.star_mask);
    hit     = 1'b0;
    if (cfg.enabled && cfg.len != '0) begin
      case (cfg.mode)
        MODE_GLOB:     hit = fin_act[cfg.len];
        MODE_CONTAINS: hit = b_found_q;
        MODE_STARTS:   hit = b_found_q;
        default:       hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (b_adv) begin
      o_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      o_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_adv) begin
      o_matched_q <= hit;
    end
  end

  assign out_o.valid   = o_valid_q;
  assign out_o.matched = o_matched_q;

endmodule

`default_nettype wire

FILE: hdl/tpfm_cfg.sv
// Configuration registers and the per-position pattern masks derived from them.
`default_nettype none

module tpfm_cfg (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  tpfm_cfg_if.sink        cfg_i,
  output tpfm_pkg::cfg_t  cfg_o
);
  import tpfm_pkg::*;

  logic                            enabled_q;
  match_mode_e                     mode_q;
  logic                            case_q;
  logic [5:0]                      plen_q;
  logic [NumWords-1:0][CfgDataW-1:0] word_q;
  logic                            wr;

  assign cfg_i.ready = 1'b1;
  assign wr = cfg_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b0;
      mode_q    <= MODE_CONTAINS;
      case_q    <= 1'b0;
      plen_q    <= '0;
      word_q    <= '0;
    end else if (wr) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_FILTER_ENABLED: enabled_q <= cfg_i.data[0];
        REG_MATCH_MODE:     mode_q    <= match_mode_e'(cfg_i.data[1:0]);
        REG_CASE_SENSITIVE: case_q    <= cfg_i.data[0];
        REG_PATTERN_LENGTH: plen_q    <= cfg_i.data[5:0];
        REG_PATTERN_WORD_0: word_q[0] <= cfg_i.data;
        REG_PATTERN_WORD_1: word_q[1] <= cfg_i.data;
        REG_PATTERN_WORD_2: word_q[2] <= cfg_i.data;
        REG_PATTERN_WORD_3: word_q[3] <= cfg_i.data;
        default: ;
      endcase
    end
  end

  logic [LenW-1:0] len;

  // Saturate the length at the pattern capacity.
  assign len = (plen_q > 6'(PatternMax)) ? LenW'(PatternMax) : LenW'(plen_q);

  always_comb begin
    cfg_o.enabled        = enabled_q;
    cfg_o.mode           = mode_q;
    cfg_o.case_sensitive = case_q;
    cfg_o.len            = len;
    for (int i = 0; i < PatternMax; i++) begin
      cfg_o.pat[i]       = fold(word_q[i / WordBytes][(i % WordBytes) * 8 +: 8], case_q);
      cfg_o.len_mask[i]  = (LenW'(i) < len);
      cfg_o.star_mask[i] = cfg_o.len_mask[i] && (cfg_o.pat[i] == ChRun);
      cfg_o.any_mask[i]  = cfg_o.len_mask[i] && (cfg_o.pat[i] == ChAny);
    end
  end

endmodule

`default_nettype wire
